// ===== rtl/bqrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqrgb_pkg
// Shared widths, register map, configuration type and gamma table for the
// Bayer quad to RGB color pipeline.
// ----------------------------------------------------------------------------
package bqrgb_pkg;

   localparam int PIX_W      = 8;
   localparam int GAIN_W     = 16;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 3 * COEF_W;
   localparam int WB_PROD_W  = PIX_W + GAIN_W;
   localparam int CCM_PROD_W = COEF_W + PIX_W + 1;
   localparam int CCM_ACC_W  = CCM_PROD_W + 2;
   localparam int CCM_FRAC_W = 10;
   localparam int WB_FRAC_W  = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_IDX_LO = 3;

   localparam logic [CCM_ACC_W-1:0] CCM_ROUND = CCM_ACC_W'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PEDESTAL     = 3'd0,
      REG_GAIN_RED     = 3'd1,
      REG_GAIN_GREEN   = 3'd2,
      REG_GAIN_BLUE    = 3'd3,
      REG_MATRIX_RED   = 3'd4,
      REG_MATRIX_GREEN = 3'd5,
      REG_MATRIX_BLUE  = 3'd6
   } csr_index_type;

   localparam logic [PIX_W-1:0]  PEDESTAL_RESET     = 8'd16;
   localparam logic [GAIN_W-1:0] GAIN_RED_RESET     = 16'd535;
   localparam logic [GAIN_W-1:0] GAIN_GREEN_RESET   = 16'd256;
   localparam logic [GAIN_W-1:0] GAIN_BLUE_RESET    = 16'd455;
   // coefficients r, g, b from high to low
   localparam logic [ROW_W-1:0]  MATRIX_RED_RESET   = 48'h061E_FE98_FF4A;
   localparam logic [ROW_W-1:0]  MATRIX_GREEN_RESET = 48'hFEDE_06AF_FE73;
   localparam logic [ROW_W-1:0]  MATRIX_BLUE_RESET  = 48'h0011_FDB6_0638;

   typedef struct packed {
      logic [PIX_W-1:0]  pedestal;
      logic [GAIN_W-1:0] gain_red;
      logic [GAIN_W-1:0] gain_green;
      logic [GAIN_W-1:0] gain_blue;
      logic [ROW_W-1:0]  matrix_row_red;
      logic [ROW_W-1:0]  matrix_row_green;
      logic [ROW_W-1:0]  matrix_row_blue;
   } cfg_type;

   localparam logic [PIX_W-1:0] GAMMA_ROM [0:255] = '{
        8'd0,   8'd13,  8'd22,  8'd28,  8'd34,  8'd38,  8'd42,  8'd46,
        8'd50,  8'd53,  8'd56,  8'd59,  8'd61,  8'd64,  8'd66,  8'd69,
        8'd71,  8'd73,  8'd75,  8'd77,  8'd79,  8'd81,  8'd83,  8'd85,
        8'd86,  8'd88,  8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,
        8'd99,  8'd101, 8'd102, 8'd104, 8'd105, 8'd106, 8'd108, 8'd109,
        8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd117, 8'd118, 8'd119,
        8'd120, 8'd121, 8'd122, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128,
        8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
        8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143, 8'd144,
        8'd145, 8'd146, 8'd147, 8'd148, 8'd148, 8'd149, 8'd150, 8'd151,
        8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156, 8'd157, 8'd158,
        8'd159, 8'd159, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164,
        8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170, 8'd170,
        8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176,
        8'd177, 8'd178, 8'd178, 8'd179, 8'd180, 8'd180, 8'd181, 8'd182,
        8'd182, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187, 8'd187,
        8'd188, 8'd189, 8'd189, 8'd190, 8'd190, 8'd191, 8'd192, 8'd192,
        8'd193, 8'd194, 8'd194, 8'd195, 8'd196, 8'd196, 8'd197, 8'd197,
        8'd198, 8'd199, 8'd199, 8'd200, 8'd200, 8'd201, 8'd202, 8'd202,
        8'd203, 8'd203, 8'd204, 8'd205, 8'd205, 8'd206, 8'd206, 8'd207,
        8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd210, 8'd211, 8'd212,
        8'd212, 8'd213, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
        8'd216, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd220,
        8'd221, 8'd221, 8'd222, 8'd222, 8'd223, 8'd223, 8'd224, 8'd224,
        8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd228, 8'd229,
        8'd229, 8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233,
        8'd233, 8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd236, 8'd237,
        8'd237, 8'd238, 8'd238, 8'd238, 8'd239, 8'd239, 8'd240, 8'd240,
        8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244,
        8'd245, 8'd245, 8'd246, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248,
        8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd251,
        8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255
   };

endpackage

// ===== rtl/bqrgb_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqrgb_csr
// Register file behind the APB-style port: black level, white-balance gains
// and color matrix rows.
// ----------------------------------------------------------------------------
module bqrgb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bqrgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bqrgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bqrgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output bqrgb_pkg::cfg_type               cfg
);

   bqrgb_pkg::cfg_type       cfg_ff;
   bqrgb_pkg::csr_index_type index;
   logic                     wr_en;

   assign index      = bqrgb_pkg::csr_index_type'(
                          csr_paddr[bqrgb_pkg::CSR_IDX_LO +: bqrgb_pkg::CSR_IDX_W]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pedestal         <= bqrgb_pkg::PEDESTAL_RESET;
         cfg_ff.gain_red         <= bqrgb_pkg::GAIN_RED_RESET;
         cfg_ff.gain_green       <= bqrgb_pkg::GAIN_GREEN_RESET;
         cfg_ff.gain_blue        <= bqrgb_pkg::GAIN_BLUE_RESET;
         cfg_ff.matrix_row_red   <= bqrgb_pkg::MATRIX_RED_RESET;
         cfg_ff.matrix_row_green <= bqrgb_pkg::MATRIX_GREEN_RESET;
         cfg_ff.matrix_row_blue  <= bqrgb_pkg::MATRIX_BLUE_RESET;
      end else if (wr_en) begin
         unique case (index)
            bqrgb_pkg::REG_PEDESTAL: begin
               cfg_ff.pedestal <= csr_pwdata[bqrgb_pkg::PIX_W-1:0];
            end
            bqrgb_pkg::REG_GAIN_RED: begin
               cfg_ff.gain_red <= csr_pwdata[bqrgb_pkg::GAIN_W-1:0];
            end
            bqrgb_pkg::REG_GAIN_GREEN: begin
               cfg_ff.gain_green <= csr_pwdata[bqrgb_pkg::GAIN_W-1:0];
            end
            bqrgb_pkg::REG_GAIN_BLUE: begin
               cfg_ff.gain_blue <= csr_pwdata[bqrgb_pkg::GAIN_W-1:0];
            end
            bqrgb_pkg::REG_MATRIX_RED: begin
               cfg_ff.matrix_row_red <= csr_pwdata[bqrgb_pkg::ROW_W-1:0];
            end
            bqrgb_pkg::REG_MATRIX_GREEN: begin
               cfg_ff.matrix_row_green <= csr_pwdata[bqrgb_pkg::ROW_W-1:0];
            end
            bqrgb_pkg::REG_MATRIX_BLUE: begin
               cfg_ff.matrix_row_blue <= csr_pwdata[bqrgb_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bqrgb_pkg::REG_PEDESTAL:     csr_prdata = 64'(cfg_ff.pedestal);
         bqrgb_pkg::REG_GAIN_RED:     csr_prdata = 64'(cfg_ff.gain_red);
         bqrgb_pkg::REG_GAIN_GREEN:   csr_prdata = 64'(cfg_ff.gain_green);
         bqrgb_pkg::REG_GAIN_BLUE:    csr_prdata = 64'(cfg_ff.gain_blue);
         bqrgb_pkg::REG_MATRIX_RED:   csr_prdata = 64'(cfg_ff.matrix_row_red);
         bqrgb_pkg::REG_MATRIX_GREEN: csr_prdata = 64'(cfg_ff.matrix_row_green);
         bqrgb_pkg::REG_MATRIX_BLUE:  csr_prdata = 64'(cfg_ff.matrix_row_blue);
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/bqrgb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqrgb_front
// Stages 1 and 2: black level subtraction with green averaging, then
// white-balance gain with clamp to 8 bits.
// ----------------------------------------------------------------------------
module bqrgb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  bqrgb_pkg::cfg_type          cfg,
   input  logic                        in_valid,
   input  logic [bqrgb_pkg::PIX_W-1:0] blue_sample,
   input  logic [bqrgb_pkg::PIX_W-1:0] green_blue_row,
   input  logic [bqrgb_pkg::PIX_W-1:0] green_red_row,
   input  logic [bqrgb_pkg::PIX_W-1:0] red_sample,
   output logic                        s1_valid,
   output logic                        out_valid,
   output logic [bqrgb_pkg::PIX_W-1:0] out_red,
   output logic [bqrgb_pkg::PIX_W-1:0] out_green,
   output logic [bqrgb_pkg::PIX_W-1:0] out_blue
);

   localparam int PW = bqrgb_pkg::PIX_W;
   localparam int MW = bqrgb_pkg::WB_PROD_W;
   localparam int FW = bqrgb_pkg::WB_FRAC_W;

   logic          v1_ff, v2_ff;
   logic [PW-1:0] r1_ff, g1_ff, b1_ff;
   logic [PW-1:0] r1_in, g1_in, b1_in;
   logic [PW-1:0] gb1, gr1;
   logic [PW:0]   gsum;
   logic [PW-1:0] r2_ff, g2_ff, b2_ff;
   logic [PW-1:0] r2_in, g2_in, b2_in;
   logic [MW-1:0] rp, gp, bp;

   function automatic logic [PW-1:0] sub_floor0(input logic [PW-1:0] s,
                                                input logic [PW-1:0] k);
      return (s > k) ? PW'(s - k) : '0;
   endfunction

   function automatic logic [PW-1:0] clamp_wb(input logic [MW-1:0] p);
      return (|p[MW-1:FW+PW]) ? {PW{1'b1}} : p[FW+PW-1:FW];
   endfunction

   // stage 1
   always_comb begin
      b1_in = sub_floor0(blue_sample, cfg.pedestal);
      gb1   = sub_floor0(green_blue_row, cfg.pedestal);
      gr1   = sub_floor0(green_red_row, cfg.pedestal);
      r1_in = sub_floor0(red_sample, cfg.pedestal);
      gsum  = {1'b0, gb1} + {1'b0, gr1};
      g1_in = gsum[PW:1];
   end

   // stage 2
   always_comb begin
      rp    = MW'(r1_ff) * MW'(cfg.gain_red);
      gp    = MW'(g1_ff) * MW'(cfg.gain_green);
      bp    = MW'(b1_ff) * MW'(cfg.gain_blue);
      r2_in = clamp_wb(rp);
      g2_in = clamp_wb(gp);
      b2_in = clamp_wb(bp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ff <= r1_in;
         g1_ff <= g1_in;
         b1_ff <= b1_in;
         r2_ff <= r2_in;
         g2_ff <= g2_in;
         b2_ff <= b2_in;
      end
   end

   assign s1_valid  = v1_ff;
   assign out_valid = v2_ff;
   assign out_red   = r2_ff;
   assign out_green = g2_ff;
   assign out_blue  = b2_ff;

endmodule

// ===== rtl/bqrgb_ccm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqrgb_ccm
// Stages 3 and 4: signed Q10 color matrix, nine registered products, then
// rounding sum, shift and clamp to 0..255.
// ----------------------------------------------------------------------------
module bqrgb_ccm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  bqrgb_pkg::cfg_type          cfg,
   input  logic                        in_valid,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_red,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_green,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_blue,
   output logic                        s3_valid,
   output logic                        out_valid,
   output logic [bqrgb_pkg::PIX_W-1:0] out_red,
   output logic [bqrgb_pkg::PIX_W-1:0] out_green,
   output logic [bqrgb_pkg::PIX_W-1:0] out_blue
);

   localparam int PW = bqrgb_pkg::PIX_W;
   localparam int CW = bqrgb_pkg::COEF_W;
   localparam int XW = bqrgb_pkg::CCM_PROD_W;
   localparam int AW = bqrgb_pkg::CCM_ACC_W;
   localparam int FW = bqrgb_pkg::CCM_FRAC_W;

   logic                 v3_ff, v4_ff;
   // row-major: output channel, then input r, g, b
   logic signed [XW-1:0] prod_ff [0:2][0:2];
   logic signed [XW-1:0] prod_in [0:2][0:2];
   logic [bqrgb_pkg::ROW_W-1:0] rows [0:2];
   logic signed [PW:0]   pix [0:2];
   logic signed [AW-1:0] acc [0:2];
   logic [PW-1:0]        ch_ff [0:2];
   logic [PW-1:0]        ch_in [0:2];

   assign rows[0] = cfg.matrix_row_red;
   assign rows[1] = cfg.matrix_row_green;
   assign rows[2] = cfg.matrix_row_blue;
   assign pix[0]  = $signed({1'b0, in_red});
   assign pix[1]  = $signed({1'b0, in_green});
   assign pix[2]  = $signed({1'b0, in_blue});

   // stage 3
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[o][i] = $signed(rows[o][(2 - i) * CW +: CW]) * pix[i];
         end
      end
   end

   // stage 4
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         acc[o] = $signed(bqrgb_pkg::CCM_ROUND)
                + AW'(prod_ff[o][0]) + AW'(prod_ff[o][1]) + AW'(prod_ff[o][2]);
         if (acc[o][AW-1]) begin
            ch_in[o] = '0;
         end else if (|acc[o][AW-2:FW+PW]) begin
            ch_in[o] = {PW{1'b1}};
         end else begin
            ch_in[o] = acc[o][FW+PW-1:FW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         ch_ff   <= ch_in;
      end
   end

   assign s3_valid  = v3_ff;
   assign out_valid = v4_ff;
   assign out_red   = ch_ff[0];
   assign out_green = ch_ff[1];
   assign out_blue  = ch_ff[2];

endmodule

// ===== rtl/bqrgb_gamma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqrgb_gamma
// Stage 5: per-channel gamma table lookup into the output register.
// ----------------------------------------------------------------------------
module bqrgb_gamma (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_red,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_green,
   input  logic [bqrgb_pkg::PIX_W-1:0] in_blue,
   output logic                        out_valid,
   output logic [bqrgb_pkg::PIX_W-1:0] out_red,
   output logic [bqrgb_pkg::PIX_W-1:0] out_green,
   output logic [bqrgb_pkg::PIX_W-1:0] out_blue
);

   logic                        v5_ff;
   logic [bqrgb_pkg::PIX_W-1:0] r5_ff, g5_ff, b5_ff;
   logic [bqrgb_pkg::PIX_W-1:0] r5_in, g5_in, b5_in;

   always_comb begin
      r5_in = bqrgb_pkg::GAMMA_ROM[in_red];
      g5_in = bqrgb_pkg::GAMMA_ROM[in_green];
      b5_in = bqrgb_pkg::GAMMA_ROM[in_blue];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r5_ff <= r5_in;
         g5_ff <= g5_in;
         b5_ff <= b5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_red   = r5_ff;
   assign out_green = g5_ff;
   assign out_blue  = b5_ff;

endmodule

// ===== rtl/bayer_quad_to_rgb_isp.sv =====
`timescale 1ns / 1ps
// throughput: one Bayer quad per cycle while not stalled, set by the five-stage pipeline
// a stall on the result side while rsp_valid is high freezes every stage at once and holds req_stall high
// synchronous reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// bayer_quad_to_rgb_isp
// Bayer BGGR quad to gamma-encoded RGB: black level, white balance, color
// matrix and gamma table, with an APB-style register port.
// ----------------------------------------------------------------------------
module bayer_quad_to_rgb_isp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bqrgb_pkg::PIX_W-1:0]      req_blue_sample,
   input  logic [bqrgb_pkg::PIX_W-1:0]      req_green_blue_row,
   input  logic [bqrgb_pkg::PIX_W-1:0]      req_green_red_row,
   input  logic [bqrgb_pkg::PIX_W-1:0]      req_red_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bqrgb_pkg::PIX_W-1:0]      rsp_out_red,
   output logic [bqrgb_pkg::PIX_W-1:0]      rsp_out_green,
   output logic [bqrgb_pkg::PIX_W-1:0]      rsp_out_blue,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bqrgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bqrgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bqrgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   bqrgb_pkg::cfg_type          cfg;
   logic                        advance;
   logic                        s1_valid, s2_valid, s3_valid, s4_valid;
   logic [bqrgb_pkg::PIX_W-1:0] wb_red, wb_green, wb_blue;
   logic [bqrgb_pkg::PIX_W-1:0] cc_red, cc_green, cc_blue;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   bqrgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bqrgb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg),
      .in_valid       (req_valid),
      .blue_sample    (req_blue_sample),
      .green_blue_row (req_green_blue_row),
      .green_red_row  (req_green_red_row),
      .red_sample     (req_red_sample),
      .s1_valid       (s1_valid),
      .out_valid      (s2_valid),
      .out_red        (wb_red),
      .out_green      (wb_green),
      .out_blue       (wb_blue)
   );

   bqrgb_ccm u_ccm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (s2_valid),
      .in_red    (wb_red),
      .in_green  (wb_green),
      .in_blue   (wb_blue),
      .s3_valid  (s3_valid),
      .out_valid (s4_valid),
      .out_red   (cc_red),
      .out_green (cc_green),
      .out_blue  (cc_blue)
   );

   bqrgb_gamma u_gamma (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid),
      .in_red    (cc_red),
      .in_green  (cc_green),
      .in_blue   (cc_blue),
      .out_valid (rsp_valid),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue)
   );

   // an accepted request reaches the output when the result side does not stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("request did not reach output in five cycles");

   // frozen stages keep their requests
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      (!advance && s2_valid && s3_valid) |=> (s2_valid && s3_valid))
      else $error("stalled pipeline lost a request");

   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      (!advance && s1_valid) |=> s1_valid)
      else $error("stalled first stage lost a request");

   // pedestal write lands
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite
         && csr_paddr[5:3] == bqrgb_pkg::REG_PEDESTAL)
      |=> cfg.pedestal == $past(csr_pwdata[bqrgb_pkg::PIX_W-1:0]))
      else $error("pedestal write not applied");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
